/* rtl/core/sdspi_pkg.sv */
// Package for the SD card SPI-mode init and block read unit.
// Holds phase and command codes, command tables and result kinds; no dependencies.
`default_nettype none
package sdspi_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int SYNC_BYTES_DEF  = 10;

  typedef enum logic [3:0] {
    P_IDLE, P_PWR_WAIT, P_SYNC, P_PRE, P_CMD, P_R1, P_EXTRA, P_TOKEN,
    P_DATA, P_CRC, P_POST1, P_POST2, P_OPC_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    C_GO_IDLE, C_IF_COND, C_APP, C_OP_COND, C_OCR, C_READ
  } cmd_t;

  localparam logic [1:0] FUNC_INIT = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_BYTE = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  localparam logic [1:0] K_XFER = 2'd0;
  localparam logic [1:0] K_WAIT = 2'd1;
  localparam logic [1:0] K_DATA = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  localparam logic [2:0] REG_IDLE_RETRY  = 3'd0;
  localparam logic [2:0] REG_OPC_RETRY   = 3'd1;
  localparam logic [2:0] REG_R1_POLL     = 3'd2;
  localparam logic [2:0] REG_TOKEN_POLL  = 3'd3;
  localparam logic [2:0] REG_PWR_WAIT    = 3'd4;
  localparam logic [2:0] REG_OPC_WAIT    = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic       cs_active;
    logic [7:0] wait_ms;
    logic       status;
    logic [7:0] r1_value;
    logic [7:0] token;
    logic       last;
  } res_t;

  // Command frame byte i (0..5) for a command and byte address.
  function automatic logic [7:0] frame_byte(cmd_t c, logic [31:0] addr, logic [2:0] i);
    logic [5:0]  code;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    code = 6'd0; arg = 32'd0; crc = 8'h00;
    unique case (c)
      C_GO_IDLE: begin code = 6'd0;  crc = 8'h94; end
      C_IF_COND: begin code = 6'd8;  arg = 32'h0000_01AA; crc = 8'h86; end
      C_APP:     code = 6'd55;
      C_OP_COND: begin code = 6'd41; arg = 32'h4000_0000; end
      C_OCR:     code = 6'd58;
      C_READ:    begin code = 6'd17; arg = addr; end
      default:   code = 6'd0;
    endcase
    unique case (i)
      3'd0:    b = {2'b01, code};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc | 8'h01;
    endcase
    return b;
  endfunction

  function automatic res_t mk(logic [1:0] kind, logic [7:0] v, logic cs, logic [7:0] ms,
                              logic st, logic [7:0] r1, logic [7:0] tok, logic lst);
    res_t r;
    r.kind = kind; r.value_byte = v; r.cs_active = cs; r.wait_ms = ms;
    r.status = st; r.r1_value = r1; r.token = tok; r.last = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sd_card_spi_init_and_block_read_unit.sv */
// Top level of the SD card SPI-mode init and single-block read sequencer.
// Depends on sdspi_pkg for codes, command tables and the result struct.
//
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid/tready    | tdata {rx_byte, block_addr, func}
//  out_    | out | tvalid/tready    | tdata fields, tlast = last
//  cfg_    | in  | wr_en            | index 3 bit, data 12 bit
//
// Each item is one sequencer step: the item register feeds combinational logic into
// a four-entry result queue. An item causes up to two results (a data byte plus the
// next transfer). Reset (synchronous, rst_n low) sets phase idle and the state and
// config registers to defaults. A stall on out_ holds the queue; in_tready drops
// unless the queue has room for two results each for any held item and the next.
`default_nettype none
module sd_card_spi_init_and_block_read_unit #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int SYNC_BYTES  = sdspi_pkg::SYNC_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] func, [24:2] block_addr, [32:25] rx_byte, [39:33] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] kind, [9:2] value_byte, [10] cs_active, [18:11] wait_ms, [19] status,
  // [27:20] r1_value, [35:28] token, [39:36] zero
  output logic [39:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  localparam int BIW = $clog2(BLOCK_BYTES + 1);
  localparam int IW  = (BIW > 6) ? BIW : 6;
  localparam logic [IW-1:0] BLK_LAST = IW'(BLOCK_BYTES - 1);
  localparam logic [IW-1:0] BLK_N    = IW'(BLOCK_BYTES);
  localparam logic [IW-1:0] SYNC_N   = IW'(SYNC_BYTES + 1);

  // configuration
  logic [7:0]  idle_lim_r, opc_lim_r, pwr_ms_r, opc_ms_r;
  logic [9:0]  r1_lim_r;
  logic [11:0] tok_lim_r;

  // sequencer state
  sdspi_pkg::phase_t phase_r, phase_nxt;
  sdspi_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [7:0]  att_r, att_nxt, wait_r, wait_nxt;
  logic [11:0] poll_r, poll_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  rsp0_r, rsp1_r, rsp4_r, rsp0_nxt, rsp1_nxt, rsp4_nxt;

  // input register
  logic        iv_r;
  logic [1:0]  func_r;
  logic [22:0] blk_r;
  logic [7:0]  rx_r;

  // result queue
  sdspi_pkg::res_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;

  sdspi_pkg::res_t ra, rb;
  logic [1:0] nres;

  logic [11:0] r1_eff, tok_eff;
  logic [11:0] poll_inc;

  // worst case: item in register plus next item, two results each
  assign in_tready = (cnt_r <= 3'd0) || (cnt_r == 3'd0) ? 1'b1 :
                     (3'(cnt_r) + (iv_r ? 3'd2 : 3'd0) <= 3'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= in_tvalid && in_tready;
    end
    if (in_tvalid && in_tready) begin
      func_r <= in_tdata[1:0];
      blk_r  <= in_tdata[24:2];
      rx_r   <= in_tdata[32:25];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_lim_r <= 8'd100; opc_lim_r <= 8'd100; r1_lim_r <= 10'd512;
      tok_lim_r <= 12'd1562; pwr_ms_r <= 8'd1; opc_ms_r <= 8'd10;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sdspi_pkg::REG_IDLE_RETRY: idle_lim_r <= cfg_data[7:0];
        sdspi_pkg::REG_OPC_RETRY:  opc_lim_r  <= cfg_data[7:0];
        sdspi_pkg::REG_R1_POLL:    r1_lim_r   <= cfg_data[9:0];
        sdspi_pkg::REG_TOKEN_POLL: tok_lim_r  <= cfg_data;
        sdspi_pkg::REG_PWR_WAIT:   pwr_ms_r   <= cfg_data[7:0];
        sdspi_pkg::REG_OPC_WAIT:   opc_ms_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign r1_eff   = (r1_lim_r == 10'd0) ? 12'd1 : {2'b00, r1_lim_r};
  assign tok_eff  = (tok_lim_r == 12'd0) ? 12'd1 : tok_lim_r;
  assign poll_inc = poll_r + 12'd1;

  // next state and results of one step
  always_comb begin
    logic [7:0] rr;
    logic       do_frame, do_fin, do_opc, do_round, do_sync;
    sdspi_pkg::cmd_t fsel;
    logic       fst;
    logic [7:0] fr1, ftok;
    logic [IW-1:0] ii;
    phase_nxt = phase_r; cmd_nxt = cmd_r; att_nxt = att_r; wait_nxt = wait_r;
    poll_nxt = poll_r; idx_nxt = idx_r; addr_nxt = addr_r;
    rsp0_nxt = rsp0_r; rsp1_nxt = rsp1_r; rsp4_nxt = rsp4_r;
    ra = '0; rb = '0; nres = 2'd0;
    do_frame = 1'b0; do_fin = 1'b0; do_opc = 1'b0; do_round = 1'b0; do_sync = 1'b0;
    fsel = sdspi_pkg::C_GO_IDLE; fst = 1'b0; fr1 = 8'd0; ftok = 8'd0; rr = rsp0_r;
    ii = idx_r + IW'(1);
    if (iv_r) begin
      unique case (func_r)
        sdspi_pkg::FUNC_INIT: begin
          if (phase_r == sdspi_pkg::P_IDLE) begin
            att_nxt = 8'd0;
            if (pwr_ms_r != 8'd0) begin
              phase_nxt = sdspi_pkg::P_PWR_WAIT; wait_nxt = pwr_ms_r;
              ra = sdspi_pkg::mk(sdspi_pkg::K_WAIT, 8'd0, 1'b0, pwr_ms_r, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              nres = 2'd1;
            end else do_sync = 1'b1;
          end
        end
        sdspi_pkg::FUNC_READ: begin
          if (phase_r == sdspi_pkg::P_IDLE) begin
            addr_nxt = {blk_r, 9'd0}; rsp1_nxt = 8'hFF;
            do_frame = 1'b1; fsel = sdspi_pkg::C_READ;
          end
        end
        sdspi_pkg::FUNC_TICK: begin
          if (phase_r == sdspi_pkg::P_PWR_WAIT || phase_r == sdspi_pkg::P_OPC_WAIT) begin
            if (wait_r > 8'd1) wait_nxt = wait_r - 8'd1;
            else begin
              wait_nxt = 8'd0;
              if (phase_r == sdspi_pkg::P_PWR_WAIT) do_sync = 1'b1;
              else do_opc = 1'b1;
            end
          end
        end
        default: begin
          unique case (phase_r)
            sdspi_pkg::P_SYNC: begin
              idx_nxt = ii;
              if (ii < SYNC_N) begin
                ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b0, 8'd0, 1'b0, 8'd0,
                                   8'd0, 1'b0);
                nres = 2'd1;
              end else begin do_frame = 1'b1; fsel = sdspi_pkg::C_GO_IDLE; end
            end
            sdspi_pkg::P_PRE: begin
              phase_nxt = sdspi_pkg::P_CMD; idx_nxt = '0;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER,
                                 sdspi_pkg::frame_byte(cmd_r, addr_r, 3'd0), 1'b1,
                                 8'd0, 1'b0, 8'd0, 8'd0, 1'b0);
              nres = 2'd1;
            end
            sdspi_pkg::P_CMD: begin
              idx_nxt = ii; nres = 2'd1;
              if (ii < IW'(6)) begin
                ra = sdspi_pkg::mk(sdspi_pkg::K_XFER,
                                   sdspi_pkg::frame_byte(cmd_r, addr_r, ii[2:0]), 1'b1,
                                   8'd0, 1'b0, 8'd0, 8'd0, 1'b0);
              end else begin
                phase_nxt = sdspi_pkg::P_R1; poll_nxt = 12'd0;
                ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                   8'd0, 1'b0);
              end
            end
            sdspi_pkg::P_R1: begin
              poll_nxt = poll_inc; nres = 2'd1;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              if (!(rx_r[7] && poll_inc < r1_eff)) begin
                rsp0_nxt = rx_r;
                if ((cmd_r == sdspi_pkg::C_IF_COND || cmd_r == sdspi_pkg::C_OCR) &&
                    rx_r <= 8'd1) begin
                  phase_nxt = sdspi_pkg::P_EXTRA; idx_nxt = IW'(1);
                end else if (cmd_r == sdspi_pkg::C_READ && rx_r != 8'hFF) begin
                  phase_nxt = sdspi_pkg::P_TOKEN; poll_nxt = 12'd0;
                end else phase_nxt = sdspi_pkg::P_POST1;
              end
            end
            sdspi_pkg::P_EXTRA: begin
              if (idx_r == IW'(1)) rsp1_nxt = rx_r;
              if (idx_r == IW'(4)) rsp4_nxt = rx_r;
              idx_nxt = ii;
              if (ii >= IW'(5)) phase_nxt = sdspi_pkg::P_POST1;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              nres = 2'd1;
            end
            sdspi_pkg::P_TOKEN: begin
              poll_nxt = poll_inc; nres = 2'd1;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              if (!(rx_r == 8'hFF && poll_inc < tok_eff)) begin
                rsp1_nxt = rx_r;
                if (rx_r == 8'hFE) begin phase_nxt = sdspi_pkg::P_DATA; idx_nxt = '0; end
                else phase_nxt = sdspi_pkg::P_POST1;
              end
            end
            sdspi_pkg::P_DATA: begin
              ra = sdspi_pkg::mk(sdspi_pkg::K_DATA, rx_r, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0,
                                 idx_r == BLK_LAST);
              rb = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              nres = 2'd2;
              idx_nxt = ii;
              if (ii >= BLK_N) begin phase_nxt = sdspi_pkg::P_CRC; idx_nxt = '0; end
            end
            sdspi_pkg::P_CRC: begin
              idx_nxt = ii;
              if (ii >= IW'(2)) phase_nxt = sdspi_pkg::P_POST1;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b1, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              nres = 2'd1;
            end
            sdspi_pkg::P_POST1: begin
              phase_nxt = sdspi_pkg::P_POST2;
              ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b0, 8'd0, 1'b0, 8'd0,
                                 8'd0, 1'b0);
              nres = 2'd1;
            end
            sdspi_pkg::P_POST2: begin
              unique case (cmd_r)
                sdspi_pkg::C_GO_IDLE: begin
                  if (rsp0_r == 8'h01) begin do_frame = 1'b1; fsel = sdspi_pkg::C_IF_COND; end
                  else if (att_r >= idle_lim_r) begin do_fin = 1'b1; fst = 1'b1; end
                  else begin
                    att_nxt = att_r + 8'd1; do_frame = 1'b1; fsel = sdspi_pkg::C_GO_IDLE;
                  end
                end
                sdspi_pkg::C_IF_COND: begin
                  if (rsp0_r != 8'h01 || rsp4_r != 8'hAA) begin do_fin = 1'b1; fst = 1'b1; end
                  else begin att_nxt = 8'd0; do_frame = 1'b1; fsel = sdspi_pkg::C_APP; end
                end
                sdspi_pkg::C_APP: begin
                  if (rsp0_r < 8'd2) begin do_frame = 1'b1; fsel = sdspi_pkg::C_OP_COND; end
                  else do_round = 1'b1;
                end
                sdspi_pkg::C_OP_COND: do_round = 1'b1;
                sdspi_pkg::C_OCR: begin do_fin = 1'b1; fst = ~rsp1_r[7]; end
                default: begin
                  do_fin = 1'b1; fst = (rsp1_r != 8'hFE); fr1 = rsp0_r; ftok = rsp1_r;
                end
              endcase
            end
            default: ;
          endcase
        end
      endcase
    end
    // end of ACMD41 round
    if (do_round) begin
      if (rr == 8'd0) begin do_frame = 1'b1; fsel = sdspi_pkg::C_OCR; end
      else if (opc_ms_r != 8'd0) begin
        phase_nxt = sdspi_pkg::P_OPC_WAIT; wait_nxt = opc_ms_r;
        ra = sdspi_pkg::mk(sdspi_pkg::K_WAIT, 8'd0, 1'b0, opc_ms_r, 1'b0, 8'd0, 8'd0,
                           1'b0);
        nres = 2'd1;
      end else do_opc = 1'b1;
    end
    // retry ACMD41 round
    if (do_opc) begin
      if (att_r >= opc_lim_r) begin do_fin = 1'b1; fst = 1'b1; end
      else begin att_nxt = att_r + 8'd1; do_frame = 1'b1; fsel = sdspi_pkg::C_APP; end
    end
    if (do_sync) begin
      phase_nxt = sdspi_pkg::P_SYNC; idx_nxt = '0;
      ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0);
      nres = 2'd1;
    end
    if (do_frame) begin
      cmd_nxt = fsel; phase_nxt = sdspi_pkg::P_PRE;
      ra = sdspi_pkg::mk(sdspi_pkg::K_XFER, 8'hFF, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0);
      nres = 2'd1;
    end
    if (do_fin) begin
      phase_nxt = sdspi_pkg::P_IDLE;
      ra = sdspi_pkg::mk(sdspi_pkg::K_DONE, 8'd0, 1'b0, 8'd0, fst, fr1, ftok, 1'b0);
      nres = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::P_IDLE; cmd_r <= sdspi_pkg::C_GO_IDLE;
      att_r <= 8'd0; wait_r <= 8'd0; poll_r <= 12'd0; idx_r <= '0; addr_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt; cmd_r <= cmd_nxt; att_r <= att_nxt; wait_r <= wait_nxt;
      poll_r <= poll_nxt; idx_r <= idx_nxt; addr_r <= addr_nxt;
    end
    rsp0_r <= rsp0_nxt; rsp1_r <= rsp1_nxt; rsp4_r <= rsp4_nxt;
  end

  // result queue: push up to two, pop one
  logic pop;
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 2'd0; wr_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      rd_r  <= rd_r + (pop ? 2'd1 : 2'd0);
      wr_r  <= wr_r + nres;
      cnt_r <= cnt_r + {1'b0, nres} - (pop ? 3'd1 : 3'd0);
    end
    if (nres != 2'd0) q_r[wr_r] <= ra;
    if (nres == 2'd2) q_r[wr_r + 2'd1] <= rb;
  end

  sdspi_pkg::res_t head;
  assign head       = q_r[rd_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tlast  = head.last;
  assign out_tdata  = {4'd0, head.token, head.r1_value, head.status, head.wait_ms,
                       head.cs_active, head.value_byte, head.kind};
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Testbench for the SD card SPI-mode init and single-block read unit.
// Depends on sdspi_pkg and the RTL top; a card responder steers the stimulus
// and an in-file sequencer model predicts every result item.
`timescale 1ns / 1ps
module testbench;
  import sdspi_pkg::*;

  localparam int SYNC_CNT  = 10;
  localparam int BLK_BYTES = 512;
  localparam int PHASE_ITEMS = 320;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  sd_card_spi_init_and_block_read_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Sequencer model: settings and state
  logic [7:0]  lim_idle, lim_opc, pwr_ms, opc_ms;
  logic [9:0]  lim_r1;
  logic [11:0] lim_tok;
  phase_t      seq_phase;
  cmd_t        seq_cmd;
  logic [7:0]  tries, ms_left;
  logic [11:0] polls;
  logic [9:0]  bidx;
  logic [31:0] rd_addr;
  logic [7:0]  resp [5];

  logic [39:0] pending_items[$];
  res_t        expected_res[$];
  int          items_fed;
  int          errors;
  int          idle_mode;

  function automatic void put_res(logic [1:0] k, logic [7:0] v, logic cs, logic [7:0] ms,
                                  logic st, logic [7:0] r1, logic [7:0] tok, logic lst);
    res_t r;
    r.kind = k; r.value_byte = v; r.cs_active = cs; r.wait_ms = ms;
    r.status = st; r.r1_value = r1; r.token = tok; r.last = lst;
    expected_res.push_back(r);
  endfunction

  function automatic void xfer(logic [7:0] v, logic cs);
    put_res(K_XFER, v, cs, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0);
  endfunction

  function automatic void done(logic st, logic [7:0] r1, logic [7:0] tok);
    seq_phase = P_IDLE;
    put_res(K_DONE, 8'd0, 1'b0, 8'd0, st, r1, tok, 1'b0);
  endfunction

  // Byte i of the six-byte command frame for the current command
  function automatic logic [7:0] cmd_frame(int i);
    logic [5:0]  code;
    logic [31:0] arg;
    logic [7:0]  crc;
    code = 6'd0; arg = 32'd0; crc = 8'h00;
    case (seq_cmd)
      C_GO_IDLE: crc = 8'h94;
      C_IF_COND: begin code = 6'd8; arg = 32'h1AA; crc = 8'h86; end
      C_APP:     code = 6'd55;
      C_OP_COND: begin code = 6'd41; arg = 32'h4000_0000; end
      C_OCR:     code = 6'd58;
      default: begin code = 6'd17; arg = rd_addr; end
    endcase
    if (i == 0) return {2'b01, code};
    if (i == 5) return crc | 8'h01;
    return arg[8*(4-i) +: 8];
  endfunction

  function automatic void open_frame(cmd_t c);
    seq_cmd = c;
    seq_phase = P_PRE;
    xfer(8'hFF, 1'b0);
  endfunction

  function automatic void sync_start();
    seq_phase = P_SYNC;
    bidx = 0;
    xfer(8'hFF, 1'b0);
  endfunction

  function automatic void opcond_retry();
    if (tries >= lim_opc) done(1'b1, 8'd0, 8'd0);
    else begin
      tries++;
      open_frame(C_APP);
    end
  endfunction

  function automatic void round_end(logic [7:0] r);
    if (r == 8'd0) open_frame(C_OCR);
    else if (opc_ms != 0) begin
      seq_phase = P_OPC_WAIT;
      ms_left = opc_ms;
      put_res(K_WAIT, 8'd0, 1'b0, opc_ms, 1'b0, 8'd0, 8'd0, 1'b0);
    end else opcond_retry();
  endfunction

  function automatic void frame_done();
    case (seq_cmd)
      C_GO_IDLE: begin
        if (resp[0] == 8'h01) open_frame(C_IF_COND);
        else if (tries >= lim_idle) done(1'b1, 8'd0, 8'd0);
        else begin
          tries++;
          open_frame(C_GO_IDLE);
        end
      end
      C_IF_COND: begin
        if (resp[0] != 8'h01 || resp[4] != 8'hAA) done(1'b1, 8'd0, 8'd0);
        else begin
          tries = 0;
          open_frame(C_APP);
        end
      end
      C_APP: begin
        if (resp[0] < 2) open_frame(C_OP_COND);
        else round_end(resp[0]);
      end
      C_OP_COND: round_end(resp[0]);
      C_OCR: done(!resp[1][7], 8'd0, 8'd0);
      default: done(resp[1] != 8'hFE, resp[0], resp[1]);
    endcase
  endfunction

  function automatic void on_rx(logic [7:0] rx);
    case (seq_phase)
      P_SYNC: begin
        bidx++;
        if (bidx < SYNC_CNT + 1) xfer(8'hFF, 1'b0);
        else open_frame(C_GO_IDLE);
      end
      P_PRE: begin
        seq_phase = P_CMD;
        bidx = 0;
        xfer(cmd_frame(0), 1'b1);
      end
      P_CMD: begin
        bidx++;
        if (bidx < 6) xfer(cmd_frame(bidx), 1'b1);
        else begin
          seq_phase = P_R1;
          polls = 0;
          xfer(8'hFF, 1'b1);
        end
      end
      P_R1: begin
        polls++;
        if (rx[7] && polls < {2'b00, lim_r1}) xfer(8'hFF, 1'b1);
        else begin
          resp[0] = rx;
          if ((seq_cmd == C_IF_COND || seq_cmd == C_OCR) && rx <= 1) begin
            seq_phase = P_EXTRA;
            bidx = 1;
          end else if (seq_cmd == C_READ && rx != 8'hFF) begin
            seq_phase = P_TOKEN;
            polls = 0;
          end else seq_phase = P_POST1;
          xfer(8'hFF, 1'b1);
        end
      end
      P_EXTRA: begin
        if (bidx < 5) resp[bidx] = rx;
        bidx++;
        if (bidx >= 5) seq_phase = P_POST1;
        xfer(8'hFF, 1'b1);
      end
      P_TOKEN: begin
        polls++;
        if (rx == 8'hFF && polls < lim_tok) xfer(8'hFF, 1'b1);
        else begin
          resp[1] = rx;
          if (rx == 8'hFE) begin
            seq_phase = P_DATA;
            bidx = 0;
          end else seq_phase = P_POST1;
          xfer(8'hFF, 1'b1);
        end
      end
      P_DATA: begin
        put_res(K_DATA, rx, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0, bidx == BLK_BYTES - 1);
        bidx++;
        if (bidx >= BLK_BYTES) begin
          seq_phase = P_CRC;
          bidx = 0;
        end
        xfer(8'hFF, 1'b1);
      end
      P_CRC: begin
        bidx++;
        if (bidx >= 2) seq_phase = P_POST1;
        xfer(8'hFF, 1'b1);
      end
      P_POST1: begin
        seq_phase = P_POST2;
        xfer(8'hFF, 1'b0);
      end
      P_POST2: frame_done();
      default: ;
    endcase
  endfunction

  // Queue one item and predict what it causes
  function automatic void feed(logic [1:0] f, logic [22:0] blk, logic [7:0] rx);
    pending_items.push_back({7'd0, rx, blk, f});
    items_fed++;
    case (f)
      FUNC_INIT: if (seq_phase == P_IDLE) begin
        tries = 0;
        if (pwr_ms != 0) begin
          seq_phase = P_PWR_WAIT;
          ms_left = pwr_ms;
          put_res(K_WAIT, 8'd0, 1'b0, pwr_ms, 1'b0, 8'd0, 8'd0, 1'b0);
        end else sync_start();
      end
      FUNC_READ: if (seq_phase == P_IDLE) begin
        rd_addr = {blk, 9'd0};
        resp[1] = 8'hFF;
        open_frame(C_READ);
      end
      FUNC_BYTE: on_rx(rx);
      default: if (seq_phase == P_PWR_WAIT || seq_phase == P_OPC_WAIT) begin
        if (ms_left > 1) ms_left--;
        else begin
          ms_left = 0;
          if (seq_phase == P_PWR_WAIT) sync_start();
          else opcond_retry();
        end
      end
    endcase
  endfunction

  // Card responder: mostly well-formed answers, some bad ones
  function automatic logic [7:0] card_byte();
    int r;
    r = $urandom_range(15);
    case (seq_phase)
      P_R1: begin
        if (r < 2) return 8'hFF;
        if (r == 2) return $urandom_range(255);
        case (seq_cmd)
          C_OP_COND: return (r < 10) ? 8'h00 : 8'h01;
          C_APP:     return (r < 13) ? 8'h01 : 8'h05;
          C_OCR, C_READ: return 8'h00;
          default:   return 8'h01;
        endcase
      end
      P_EXTRA: begin
        if (seq_cmd == C_IF_COND && bidx == 4) return (r < 14) ? 8'hAA : $urandom_range(255);
        if (seq_cmd == C_OCR && bidx == 1) return (r < 12) ? 8'hC0 : $urandom_range(127);
        return $urandom_range(255);
      end
      P_TOKEN: begin
        if (r < 5) return 8'hFF;
        return (r < 15) ? 8'hFE : $urandom_range(255);
      end
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic logic [22:0] pick_block();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 23'd0;
    if (r == 1) return 23'h7FFFFF;
    return $urandom_range(23'h7FFFFF);
  endfunction

  // Run transactions until the item budget is spent and the unit is idle
  task automatic run_traffic(int budget);
    int stop;
    stop = items_fed + budget;
    while (items_fed < stop || seq_phase != P_IDLE) begin
      if ($urandom_range(29) == 0)
        feed($urandom_range(3), $urandom_range(23'h7FFFFF), $urandom_range(255));
      else case (seq_phase)
        P_IDLE: if ($urandom_range(1)) feed(FUNC_INIT, pick_block(), $urandom_range(255));
                else feed(FUNC_READ, pick_block(), $urandom_range(255));
        P_PWR_WAIT, P_OPC_WAIT: feed(FUNC_TICK, $urandom_range(23'h7FFFFF), 8'd0);
        default: feed(FUNC_BYTE, $urandom_range(23'h7FFFFF), card_byte());
      endcase
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_res.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IDLE_RETRY: lim_idle = val[7:0];
      REG_OPC_RETRY:  lim_opc  = val[7:0];
      REG_R1_POLL:    lim_r1   = val[9:0];
      REG_TOKEN_POLL: lim_tok  = val;
      REG_PWR_WAIT:   pwr_ms   = val[7:0];
      default:        opc_ms   = val[7:0];
    endcase
  endtask

  task automatic write_all(int i, int o, int r1, int tok, int pw, int ow);
    write_reg(REG_IDLE_RETRY, i);
    write_reg(REG_OPC_RETRY, o);
    write_reg(REG_R1_POLL, r1);
    write_reg(REG_TOKEN_POLL, tok);
    write_reg(REG_PWR_WAIT, pw);
    write_reg(REG_OPC_WAIT, ow);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus sequence
  initial begin
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
    lim_idle = 8'd100; lim_opc = 8'd100; lim_r1 = 10'd512; lim_tok = 12'd1562;
    pwr_ms = 8'd1; opc_ms = 8'd10;
    seq_phase = P_IDLE; seq_cmd = C_GO_IDLE; tries = 0; ms_left = 0;
    polls = 0; bidx = 0; rd_addr = 0;
    foreach (resp[i]) resp[i] = 8'd0;
    items_fed = 0; errors = 0; idle_mode = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Stray bytes and ticks, read at the top block, start while busy
    feed(FUNC_BYTE, 23'd0, 8'h00);
    feed(FUNC_BYTE, 23'h7FFFFF, 8'hFF);
    feed(FUNC_TICK, 23'd0, 8'h55);
    feed(FUNC_READ, 23'h7FFFFF, 8'h00);
    feed(FUNC_INIT, 23'd0, 8'h00);
    feed(FUNC_TICK, 23'd0, 8'h00);
    run_traffic(20);
    feed(FUNC_INIT, 23'h2AAAAA, 8'hAA);
    feed(FUNC_READ, 23'h555555, 8'h55);
    run_traffic(10);

    drain();
    write_all(3, 2, 8, 6, 2, 1);
    run_traffic(PHASE_ITEMS);

    drain();
    idle_mode = 1;
    write_all(0, 0, 0, 1, 0, 0);
    run_traffic(PHASE_ITEMS);

    drain();
    idle_mode = 2;
    write_all(255, 255, 1023, 4095, 255, 255);
    run_traffic(PHASE_ITEMS);

    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Drive input items from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 17) &&
          !(idle_mode == 1 && $urandom_range(99) < 77)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_items.pop_front();
      end else in_tvalid <= 1'b0;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (idle_mode == 0) out_tready <= $urandom_range(99) >= 77;
    else if (idle_mode == 1) out_tready <= $urandom_range(99) >= 17;
    else out_tready <= 1'b1;
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        e = expected_res.pop_front();
        check_field("kind", e.kind, out_tdata[1:0]);
        check_field("value_byte", e.value_byte, out_tdata[9:2]);
        check_field("cs_active", e.cs_active, out_tdata[10]);
        check_field("wait_ms", e.wait_ms, out_tdata[18:11]);
        check_field("status", e.status, out_tdata[19]);
        check_field("r1_value", e.r1_value, out_tdata[27:20]);
        check_field("token", e.token, out_tdata[35:28]);
        check_field("last", e.last, out_tlast);
      end
    end
  end

  // Watchdog on cycles without any accepted item
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

endmodule
